// File: sv/rdsa_pkg.sv
// Package for the RDS label and radiotext assembler.
// Types and constants shared by front, queue and back; no dependencies.
`default_nettype none
package rdsa_pkg;
  localparam int NAME_SEGMENTS = 4;
  localparam int TEXT_SEGMENTS = 16;
  localparam int CHARS_PER_SEGMENT = 4;
  localparam int LABEL_LEN = 2 * NAME_SEGMENTS;
  localparam int TEXT_LEN = TEXT_SEGMENTS * CHARS_PER_SEGMENT;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_LABEL = 2'd1;
  localparam logic [1:0] KIND_TEXT  = 2'd2;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam logic [1:0] AB_NONE = 2'd2;

  // Classified group passed from front to back
  typedef struct packed {
    logic       changed;
    logic       accepted;
    logic       is_label;
    logic       is_text;
    logic       ab;
    logic [3:0] seg;
    logic [15:0] block_c;
    logic [15:0] block_d;
  } group_cmd_t;
endpackage
`default_nettype wire

// File: sv/rdsa_front.sv
// Front end: accepts groups, checks PI and classifies group type.
// Depends on rdsa_pkg.
`default_nettype none
module rdsa_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [15:0]        pi_code,
  input  wire [15:0]        block_b,
  input  wire [15:0]        block_c,
  input  wire [15:0]        block_d,
  output logic              cmd_valid,
  input  wire               cmd_ready,
  output rdsa_pkg::group_cmd_t cmd
);
  import rdsa_pkg::*;
  logic [15:0] current_pi;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  // Classify the group
  always_comb begin
    cmd.changed  = (pi_code != current_pi);
    cmd.accepted = ~block_b[11];
    cmd.is_label = ~block_b[11] && (block_b[15:12] == 4'd0);
    cmd.is_text  = ~block_b[11] && (block_b[15:12] == 4'd2);
    cmd.ab       = block_b[4];
    cmd.seg      = block_b[3:0];
    cmd.block_c  = block_c;
    cmd.block_d  = block_d;
  end

  // PI tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      current_pi <= '0;
    end else if (in_valid && in_ready) begin
      current_pi <= pi_code;
    end
  end
endmodule
`default_nettype wire

// File: sv/rdsa_queue.sv
// Short FIFO of classified groups between front and back.
// Depends on rdsa_pkg.
`default_nettype none
module rdsa_queue #(
  parameter int DEPTH = rdsa_pkg::QUEUE_DEPTH
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               wr_valid,
  output logic              wr_ready,
  input  rdsa_pkg::group_cmd_t wr_data,
  output logic              rd_valid,
  input  wire               rd_ready,
  output rdsa_pkg::group_cmd_t rd_data
);
  import rdsa_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  group_cmd_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  logic wr_en, rd_en;

  assign wr_ready = (count != DEPTH[AW:0]);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  // Pointer and storage update
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        mem[wptr] <= wr_data;
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + {{AW{1'b0}}, wr_en} - {{AW{1'b0}}, rd_en};
    end
  end
endmodule
`default_nettype wire

// File: sv/rdsa_back.sv
// Back end: updates label and text stores and streams characters out.
// Depends on rdsa_pkg.
`default_nettype none
module rdsa_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               partial_text,
  input  wire               cmd_valid,
  output logic              cmd_ready,
  input  rdsa_pkg::group_cmd_t cmd,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [1:0]        kind,
  output logic [7:0]        char_value,
  output logic [5:0]        char_index,
  output logic              last,
  output logic              accepted,
  output logic              station_changed
);
  import rdsa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EMIT_LABEL, S_EMIT_TEXT, S_DONE} state_t;
  state_t state;

  logic [7:0]  label_store [LABEL_LEN];
  logic [3:0]  label_mask;
  // One word per text segment, byte 0 in the low bits; only segments whose
  // mask bit is set are ever read, so the words need no clearing
  logic [31:0] text_words [TEXT_SEGMENTS];
  logic [15:0] text_mask;
  logic [1:0]  text_ab;
  logic [6:0]  clen;
  logic [5:0]  idx;
  logic        text_clear;
  group_cmd_t  cur;
  logic        out_free;
  logic        emit_now;
  logic [31:0] cur_word;
  logic        cr_hit;

  assign cmd_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign emit_now = out_free &&
                    (state == S_EMIT_LABEL || state == S_EMIT_TEXT || state == S_DONE);
  assign cur_word = {cur.block_d[7:0], cur.block_d[15:8], cur.block_c[7:0], cur.block_c[15:8]};

  // Carriage return inside the contiguous prefix of the written segment
  always_comb begin
    cr_hit = 1'b0;
    for (int k = 0; k < CHARS_PER_SEGMENT; k++) begin
      if (cur_word[8*k +: 8] == CR_BYTE && clen > {1'b0, cur.seg, 2'(k)}) cr_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      label_mask <= '0;
      text_mask <= '0;
      text_ab <= AB_NONE;
      clen <= '0;
      for (int i = 0; i < LABEL_LEN; i++) label_store[i] <= SPACE_BYTE;
    end else begin
      if (emit_now) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            text_clear <= 1'b0;
            // Label segment; the mask restarts on station change
            if (cmd.is_label) begin
              label_store[{cmd.seg[1:0], 1'b0}] <= cmd.block_d[15:8];
              label_store[{cmd.seg[1:0], 1'b1}] <= cmd.block_d[7:0];
              label_mask <= (cmd.changed ? 4'd0 : label_mask) | (4'd1 << cmd.seg[1:0]);
            end else if (cmd.changed) begin
              label_mask <= '0;
            end
            // Text segment; restart on station change or A/B flip
            if (cmd.is_text) begin
              text_words[cmd.seg] <= {cmd.block_d[7:0], cmd.block_d[15:8],
                                      cmd.block_c[7:0], cmd.block_c[15:8]};
              text_ab <= {1'b0, cmd.ab};
              if (cmd.changed || ({1'b0, cmd.ab} != text_ab)) begin
                text_mask <= 16'd1 << cmd.seg;
                clen <= '0;
              end else begin
                text_mask <= text_mask | (16'd1 << cmd.seg);
              end
            end else if (cmd.changed) begin
              text_mask <= '0;
              clen <= '0;
              text_ab <= AB_NONE;
            end
            state <= cmd.is_label ? S_EMIT_LABEL : (cmd.is_text ? S_SCAN : S_DONE);
          end
        end
        S_SCAN: begin
          // Extend contiguous length one segment per cycle, then decide
          if (!clen[6] && text_mask[clen[5:2]]) begin
            clen <= clen + 7'd4;
          end else begin
            text_clear <= cr_hit || (&text_mask);
            if ((partial_text && clen != '0) || cr_hit || (&text_mask)) state <= S_EMIT_TEXT;
            else state <= S_DONE;
          end
        end
        S_EMIT_LABEL: begin
          if (out_free) begin
            kind <= KIND_LABEL;
            char_value <= label_store[idx[2:0]];
            char_index <= idx;
            accepted <= cur.accepted;
            station_changed <= cur.changed;
            if (label_mask != 4'hF) begin
              kind <= KIND_NONE;
              char_value <= '0;
              char_index <= '0;
              last <= 1'b1;
              state <= S_IDLE;
            end else begin
              last <= (idx == 6'(LABEL_LEN - 1));
              idx <= idx + 1'b1;
              if (idx == 6'(LABEL_LEN - 1)) begin
                label_mask <= '0;
                state <= S_IDLE;
              end
            end
          end
        end
        S_EMIT_TEXT: begin
          if (out_free) begin
            kind <= KIND_TEXT;
            char_value <= text_words[idx[5:2]][{idx[1:0], 3'b000} +: 8];
            char_index <= idx;
            accepted <= cur.accepted;
            station_changed <= cur.changed;
            last <= ({1'b0, idx} == clen - 7'd1);
            idx <= idx + 1'b1;
            if ({1'b0, idx} == clen - 7'd1) begin
              if (text_clear) begin
                text_mask <= '0;
                clen <= '0;
              end
              state <= S_IDLE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            kind <= KIND_NONE;
            char_value <= '0;
            char_index <= '0;
            last <= 1'b1;
            accepted <= cur.accepted;
            station_changed <= cur.changed;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_clen_aligned: assert property (@(posedge clk) disable iff (rst) clen[1:0] == 2'd0)
    else $error("contiguous length not segment aligned");
  a_clen_range: assert property (@(posedge clk) disable iff (rst) clen <= 7'(TEXT_LEN))
    else $error("contiguous length out of range");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == S_IDLE)
    else $error("command taken while busy");
  a_text_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT_TEXT |-> clen != '0)
    else $error("text emit with empty prefix");
`endif
endmodule
`default_nettype wire

// File: sv/rds_label_and_text_assembler_core.sv
// Top level of the RDS label and radiotext assembler.
// Depends on rdsa_pkg, rdsa_front, rdsa_queue, rdsa_back.
//  channel | dir | tdata / data fields (low bit up)
//  s_axis  | in  | pi_code[15:0] block_b[31:16] block_c[47:32] block_d[63:48]
//  m_axis  | out | char_value[7:0] char_index[13:8]; tuser kind[1:0] accepted station_changed
//  cfg     | in  | partial_text[0]
// Flow: each group passes through the queue, then the back end updates the stores and
// streams the result words; a text group first extends its contiguous prefix segment by
// segment, then decides whether to emit text.
// Reset: synchronous; clears PI, masks, lengths and A/B marker. Stalls on m_axis hold
// the back end only; the front keeps filling the two-entry queue.
`default_nettype none
module rds_label_and_text_assembler_core #(
  parameter int QUEUE_DEPTH = rdsa_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [63:0]  s_axis_tdata,   // pi_code, block_b, block_c, block_d
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // char_value, char_index, 2 zero bits
  output logic [3:0]  m_axis_tuser,   // kind, accepted, station_changed
  output logic        m_axis_tlast,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [7:0]   cfg_data        // partial_text, 7 zero bits
);
  import rdsa_pkg::*;
  group_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;
  logic partial_text;
  logic [1:0] kind;
  logic [7:0] char_value;
  logic [5:0] char_index;
  logic accepted, station_changed;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) partial_text <= 1'b0;
    else if (cfg_valid) partial_text <= cfg_data[0];
  end

  rdsa_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .pi_code(s_axis_tdata[15:0]), .block_b(s_axis_tdata[31:16]),
    .block_c(s_axis_tdata[47:32]), .block_d(s_axis_tdata[63:48]),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

  rdsa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd));

  rdsa_back u_back (
    .clk, .rst, .partial_text, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .kind, .char_value,
    .char_index, .last(m_axis_tlast), .accepted, .station_changed);

  assign m_axis_tdata = {2'b00, char_index, char_value};
  assign m_axis_tuser = {station_changed, accepted, kind};
endmodule
`default_nettype wire
